@@ rtl/core/sync_pattern_length_deframer_defines.svh @@
// assertion macros for the sync pattern length deframer
// included by files that carry concurrent assertions; no other dependencies
`ifndef SYNC_PATTERN_LENGTH_DEFRAMER_DEFINES_SVH
`define SYNC_PATTERN_LENGTH_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF

// check a property on every rising edge outside reset
`define SPLD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spld assertion failed");

// check a property on every rising edge, reset included
`define SPLD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("spld assertion failed");

`else

`define SPLD_ASSERT(lbl, clk, rst_n, prop)
`define SPLD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/core/spld_pkg.sv @@
// shared types and constants of the sync pattern length deframer
// no dependencies
`default_nettype none

package spld_pkg;

  // sync pattern and length header
  localparam int MAX_PATTERN_DEF = 16;
  localparam int LENGTH_BYTES    = 8;
  localparam int PLEN_W          = 5;
  localparam int PAT_W           = 64;
  localparam int PAT_BYTES       = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

  // configuration reset values
  localparam logic [PLEN_W-1:0] PATTERN_LENGTH_RST = 5'd10;
  localparam logic [PAT_W-1:0]  PATTERN_LOW_RST    = 64'h4154_535F_4154_4144;
  localparam logic [PAT_W-1:0]  PATTERN_HIGH_RST   = 64'h0000_0000_0000_5452;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ABORT   = 2'd2
  } kind_t;

  // one result transaction
  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/sync_pattern_length_deframer.sv @@
// sync pattern length deframer, top level
// depends on spld_pkg and sync_pattern_length_deframer_defines.svh
`default_nettype none
`include "sync_pattern_length_deframer_defines.svh"

// Takes one received byte per transaction and hunts for a programmable sync
// pattern of up to MAX_PATTERN bytes (overlapping matches allowed), then
// gathers an 8-byte little-endian length and passes that many payload bytes,
// flagging the last; a zero length gives one empty-frame result and a sync
// match inside a frame gives an abort result and restarts the header. The
// window compare, header and payload counters all update in the cycle the
// byte is accepted, and the result is registered into a two-entry output
// buffer, so a byte is accepted each cycle as long as the second buffer entry
// is free. Configuration writes take effect on the next byte.
module sync_pattern_length_deframer #(
  parameter int MAX_PATTERN = spld_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [spld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [spld_pkg::PAT_W-1:0]     cfg_wdata,
  // received bytes
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_rx_byte,
  // results
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          out_kind,
  output logic [7:0]                          out_payload_byte,
  output logic                                out_last
);
  import spld_pkg::*;

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam logic [2:0] HDR_LAST = 3'(LENGTH_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // configuration registers
  logic [PLEN_W-1:0] pattern_length_r;
  logic [PAT_W-1:0]  pattern_low_r;
  logic [PAT_W-1:0]  pattern_high_r;

  // frame state
  logic [MAX_PATTERN-1:0][7:0] win_r, win_nxt;
  logic [FILL_W-1:0]           fill_r, fill_nxt;
  phase_t                      phase_r, phase_nxt;
  logic [2:0]                  hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0]                 len_acc_r, len_acc_nxt;
  logic [63:0]                 remain_r, remain_nxt;

  // output buffer
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  logic in_fire, pop;
  logic res_valid;
  res_t res;

  logic [PAT_BYTES-1:0][7:0] pat;
  logic [PLEN_W-1:0]         len_eff;
  logic [MAX_PATTERN-1:0]    byte_eq;
  logic                      sync;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= PATTERN_LENGTH_RST;
      pattern_low_r    <= PATTERN_LOW_RST;
      pattern_high_r   <= PATTERN_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[PLEN_W-1:0];
        CFG_PATTERN_LOW:    pattern_low_r    <= cfg_wdata;
        CFG_PATTERN_HIGH:   pattern_high_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shift window and saturating fill count
  always_comb begin
    win_nxt[0] = in_rx_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
    fill_nxt = (fill_r < FILL_W'(MAX_PATTERN)) ? fill_r + 1'b1 : fill_r;
  end

  // parallel pattern compare, newest byte against the last pattern byte
  assign pat     = {pattern_high_r, pattern_low_r};
  assign len_eff = (pattern_length_r > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN)
                                                             : pattern_length_r;

  always_comb begin
    logic [PLEN_W-1:0] pidx;
    pidx = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx = len_eff - PLEN_W'(j) - 1'b1;
      if (PLEN_W'(j) < len_eff) begin
        byte_eq[j] = (win_nxt[j] == pat[pidx[3:0]]);
      end else begin
        byte_eq[j] = 1'b1;
      end
    end
  end

  assign sync = (len_eff != '0) && (PLEN_W'(fill_nxt) >= len_eff) && (&byte_eq);

  // frame sequencing and result
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    len_acc_nxt = len_acc_r;
    remain_nxt  = remain_r;
    res_valid   = 1'b0;
    res         = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, last: 1'b0};
    if (sync) begin
      phase_nxt   = PH_HEADER;
      hdr_cnt_nxt = '0;
      len_acc_nxt = '0;
      remain_nxt  = '0;
      if (phase_r == PH_HEADER || phase_r == PH_PAYLOAD) begin
        res_valid = 1'b1;
        res.kind  = KIND_ABORT;
      end
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          len_acc_nxt = len_acc_r | ({56'd0, in_rx_byte} << {hdr_cnt_r, 3'b000});
          hdr_cnt_nxt = hdr_cnt_r + 1'b1;
          if (hdr_cnt_r == HDR_LAST) begin
            hdr_cnt_nxt = '0;
            if (len_acc_nxt == '0) begin
              phase_nxt = PH_HUNT;
              res_valid = 1'b1;
              res.kind  = KIND_EMPTY;
            end else begin
              remain_nxt  = len_acc_nxt;
              len_acc_nxt = '0;
              phase_nxt   = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.payload_byte = in_rx_byte;
          res.last         = (remain_r <= 64'd1);
          if (remain_r != '0) begin
            remain_nxt = remain_r - 1'b1;
          end
          if (remain_r <= 64'd1) begin
            phase_nxt = PH_HUNT;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      phase_r   <= PH_HUNT;
      hdr_cnt_r <= '0;
    end else if (in_fire) begin
      fill_r    <= fill_nxt;
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r     <= win_nxt;
      len_acc_r <= len_acc_nxt;
      remain_r  <= remain_nxt;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_payload_byte = out_r.payload_byte;
  assign out_last         = out_r.last;

  // checks
  `SPLD_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r)
  `SPLD_ASSERT(a_payload_hdr_clear, clk, rst_n, (phase_r == PH_PAYLOAD) |-> (hdr_cnt_r == '0))
  `SPLD_ASSERT(a_payload_gives_result, clk, rst_n,
               (in_fire && phase_r == PH_PAYLOAD) |-> res_valid)

endmodule

`default_nettype wire
